// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the voice sample unit.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// combinational or implication property, sampled on clk, off in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/adsrv_pkg.sv =====
// Types, constants and helper functions of the ADSR voice sample unit.
// No dependencies.
`default_nettype none
package adsrv_pkg;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [31:0] time_since_on;
    logic [31:0] held_length;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] voice_sample;
    logic [2:0]         segment;
  } out_item_t;

  localparam logic [2:0] SEG_ATTACK  = 3'd0;
  localparam logic [2:0] SEG_DECAY   = 3'd1;
  localparam logic [2:0] SEG_SUSTAIN = 3'd2;
  localparam logic [2:0] SEG_RELEASE = 3'd3;
  localparam logic [2:0] SEG_SILENT  = 3'd4;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_VEL     = 3'd3;
  localparam logic [2:0] REG_HARM2   = 3'd4;
  localparam logic [2:0] REG_HARM3   = 3'd5;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] SUSTAIN_Q16 = 17'd52429;
  localparam logic [13:0] DECAY_DROP  = 14'd13107;

  // pipeline depths, acceptance to registered result
  localparam int ENV_LAT = 20;
  localparam int OSC_LAT = 9;

  // envelope result, one per pipeline slot
  typedef struct packed {
    logic        valid;
    logic [2:0]  seg;
    logic [16:0] env;
  } env_res_t;

  // mixed oscillator value as sign and magnitude
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } mix_t;

  // base frequency of notes 60..71, Hz in Q16
  function automatic logic [24:0] base_freq(input logic [3:0] semi);
    logic [24:0] f;
    case (semi)
      4'd0:    f = 25'd17146184;
      4'd1:    f = 25'd18165268;
      4'd2:    f = 25'd19245302;
      4'd3:    f = 25'd20390216;
      4'd4:    f = 25'd21602632;
      4'd5:    f = 25'd22913352;
      4'd6:    f = 25'd24247927;
      4'd7:    f = 25'd25690112;
      4'd8:    f = 25'd27217428;
      4'd9:    f = 25'd28835840;
      4'd10:   f = 25'd30550524;
      4'd11:   f = 25'd32366920;
      default: f = 25'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/adsrv_env.sv =====
// ADSR envelope pipeline: segment decode, numerator setup, a 17-stage
// restoring divider and a final envelope stage. Depends on adsrv_pkg.
`default_nettype none
module adsrv_env (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [31:0]       t,
  input  wire logic [31:0]       held,
  input  wire logic [23:0]       attack_time,
  input  wire logic [23:0]       decay_time,
  input  wire logic [23:0]       release_time,
  output adsrv_pkg::env_res_t    env_res
);
  import adsrv_pkg::*;

  localparam int NDIV = 17;

  // stage 0: segment and time offset
  logic        v0_r;
  logic [2:0]  seg0_r;
  logic [23:0] diff0_r;
  logic        az0_r;
  logic [2:0]  seg0_nxt;
  logic [23:0] diff0_nxt;
  logic [32:0] t4;
  logic [24:0] t2;

  always_comb begin
    t4 = {1'b0, held} + {9'd0, release_time};
    t2 = {1'b0, attack_time} + {1'b0, decay_time};
    diff0_nxt = 24'd0;
    if ({1'b0, t} >= t4) begin
      seg0_nxt = SEG_SILENT;
    end else if (t <= {8'd0, attack_time}) begin
      seg0_nxt  = SEG_ATTACK;
      diff0_nxt = t[23:0];
    end else if ({1'b0, t} <= {8'd0, t2}) begin
      seg0_nxt  = SEG_DECAY;
      diff0_nxt = t[23:0] - attack_time;
    end else if (t <= held) begin
      seg0_nxt = SEG_SUSTAIN;
    end else begin
      seg0_nxt  = SEG_RELEASE;
      diff0_nxt = t[23:0] - held[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
    seg0_r  <= seg0_nxt;
    diff0_r <= diff0_nxt;
    az0_r   <= (attack_time == 24'd0);
  end

  // stage 1: numerator and divisor
  logic        v1_r;
  logic [2:0]  seg1_r;
  logic        az1_r;
  logic [39:0] num1_r;
  logic [23:0] den1_r;
  logic [39:0] num1_nxt;
  logic [23:0] den1_nxt;

  always_comb begin
    case (seg0_r)
      SEG_ATTACK: begin
        num1_nxt = {diff0_r, 16'd0};
        den1_nxt = attack_time;
      end
      SEG_DECAY: begin
        num1_nxt = 40'(diff0_r) * 40'(DECAY_DROP);
        den1_nxt = decay_time;
      end
      SEG_RELEASE: begin
        num1_nxt = 40'(diff0_r) * 40'(SUSTAIN_Q16);
        den1_nxt = release_time;
      end
      default: begin
        num1_nxt = 40'd0;
        den1_nxt = 24'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    seg1_r <= seg0_r;
    az1_r  <= az0_r;
    num1_r <= num1_nxt;
    den1_r <= den1_nxt;
  end

  // divider: stage i settles quotient bit NDIV-1-i
  logic        dv_r   [NDIV];
  logic [2:0]  dseg_r [NDIV];
  logic        daz_r  [NDIV];
  logic [40:0] rem_r  [NDIV];
  logic [16:0] q_r    [NDIV];
  logic [23:0] den_r  [NDIV];
  logic [40:0] rem_nxt [NDIV];
  logic [16:0] q_nxt   [NDIV];

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      logic [40:0] rp;
      logic [16:0] qp;
      logic [40:0] dsh;
      rp  = (i == 0) ? {1'b0, num1_r} : rem_r[(i == 0) ? 0 : i - 1];
      qp  = (i == 0) ? 17'd0 : q_r[(i == 0) ? 0 : i - 1];
      dsh = {17'd0, ((i == 0) ? den1_r : den_r[(i == 0) ? 0 : i - 1])} << (NDIV - 1 - i);
      q_nxt[i] = qp;
      if (rp >= dsh) begin
        rem_nxt[i] = rp - dsh;
        q_nxt[i][NDIV - 1 - i] = 1'b1;
      end else begin
        rem_nxt[i] = rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NDIV; i++) dv_r[i] <= 1'b0;
    end else begin
      dv_r[0] <= v1_r;
      for (int i = 1; i < NDIV; i++) dv_r[i] <= dv_r[i - 1];
    end
    dseg_r[0] <= seg1_r;
    daz_r[0]  <= az1_r;
    den_r[0]  <= den1_r;
    for (int i = 1; i < NDIV; i++) begin
      dseg_r[i] <= dseg_r[i - 1];
      daz_r[i]  <= daz_r[i - 1];
      den_r[i]  <= den_r[i - 1];
    end
    for (int i = 0; i < NDIV; i++) begin
      rem_r[i] <= rem_nxt[i];
      q_r[i]   <= q_nxt[i];
    end
  end

  // final envelope value
  logic        ev_r;
  logic [2:0]  eseg_r;
  logic [16:0] env_r;
  logic [16:0] env_nxt;
  logic [16:0] qf;

  always_comb begin
    qf = q_r[NDIV - 1];
    case (dseg_r[NDIV - 1])
      SEG_ATTACK:  env_nxt = daz_r[NDIV - 1] ? ONE_Q16 : qf;
      SEG_DECAY:   env_nxt = ONE_Q16 - qf;
      SEG_SUSTAIN: env_nxt = SUSTAIN_Q16;
      SEG_RELEASE: env_nxt = SUSTAIN_Q16 - qf;
      default:     env_nxt = 17'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else begin
      ev_r <= dv_r[NDIV - 1];
    end
    eseg_r <= dseg_r[NDIV - 1];
    env_r  <= env_nxt;
  end

  assign env_res = '{valid: ev_r, seg: eseg_r, env: env_r};

endmodule
`default_nettype wire

// ===== rtl/adsrv_osc.sv =====
// Oscillator pipeline: note to frequency, phase of up to three harmonics,
// quarter-wave polynomial sine and mixing. Depends on adsrv_pkg.
`default_nettype none
module adsrv_osc #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic [6:0]  note,
  input  wire logic [31:0] t,
  input  wire logic        add2,
  input  wire logic        add3,
  output adsrv_pkg::mix_t  mix
);
  import adsrv_pkg::*;

  // table depth is a power of two: quantizing keeps the top TBL_BITS bits
  localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] PH_MASK = 32'hFFFF_FFFF << (32 - TBL_BITS);

  // A0: octave and base frequency
  logic [24:0] f_r;
  logic [31:0] t_r;
  logic [3:0]  oct0_r;
  logic [14:0] octp;
  logic [3:0]  oct;
  logic [6:0]  semi;

  always_comb begin
    octp = {8'd0, note} * 15'd171;      // note / 12 for note < 128
    oct  = octp[14 - 3 +: 4] & 4'hF;
    semi = note - {oct, 3'd0} - {1'b0, oct, 2'd0};
  end

  always_ff @(posedge clk) begin
    f_r    <= base_freq(semi[3:0]);
    t_r    <= t;
    oct0_r <= oct;
  end

  // A1: frequency times time, low bits only
  logic [36:0] prod_r;
  logic [3:0]  oct1_r;
  logic [56:0] prod_full;

  assign prod_full = f_r * t_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_full[36:0];
    oct1_r <= oct0_r;
  end

  // A2..A6 per harmonic lane
  logic        neg2_r [3];
  logic [16:0] x2p_r  [3];
  logic        neg3_r [3];
  logic [16:0] x3_r   [3];
  logic [16:0] sq3_r  [3];
  logic        neg4_r [3];
  logic [16:0] x4_r   [3];
  logic [16:0] sq4_r  [3];
  logic [15:0] tt4_r  [3];
  logic        neg5_r [3];
  logic [16:0] x5_r   [3];
  logic [16:0] u5_r   [3];
  logic signed [15:0] lane_r [3];

  logic [16:0] x_nxt   [3];
  logic        neg_nxt [3];
  logic [16:0] sq_nxt  [3];
  logic [15:0] tt_nxt  [3];
  logic [16:0] u_nxt   [3];
  logic signed [15:0] lane_nxt [3];

  always_comb begin
    for (int h = 0; h < 3; h++) begin
      logic [36:0] full;
      logic [41:0] sh;
      logic [31:0] p;
      logic [33:0] m1;
      logic [30:0] m2;
      logic [32:0] m3;
      logic [33:0] m4;
      logic [16:0] s;
      logic [16:0] hs;
      case (h)
        0:       full = prod_r;
        1:       full = {prod_r[35:0], 1'b0};
        default: full = prod_r + {prod_r[35:0], 1'b0};
      endcase
      sh = {full, 5'd0} >> (4'd10 - oct1_r);
      p  = sh[31:0] & PH_MASK;
      neg_nxt[h] = p[31];
      x_nxt[h]   = p[30] ? (17'd65536 - {1'b0, p[29:14]}) : {1'b0, p[29:14]};
      m1 = x2p_r[h] * x2p_r[h];
      sq_nxt[h] = m1[32:16];
      m2 = sq3_r[h] * 14'd4640;
      tt_nxt[h] = 16'd42048 - {3'd0, m2[28:16]};
      m3 = sq4_r[h] * tt4_r[h];
      u_nxt[h] = 17'd102944 - m3[32:16];
      m4 = x5_r[h] * u5_r[h];
      s  = m4[32:16];
      hs = 17'(({1'b0, s} + 18'd1) >> 1);
      if (hs > 17'd32767) hs = 17'd32767;
      lane_nxt[h] = neg5_r[h] ? -$signed(hs[15:0]) : $signed(hs[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int h = 0; h < 3; h++) begin
      neg2_r[h] <= neg_nxt[h];
      x2p_r[h]  <= x_nxt[h];
      neg3_r[h] <= neg2_r[h];
      x3_r[h]   <= x2p_r[h];
      sq3_r[h]  <= sq_nxt[h];
      neg4_r[h] <= neg3_r[h];
      x4_r[h]   <= x3_r[h];
      sq4_r[h]  <= sq3_r[h];
      tt4_r[h]  <= tt_nxt[h];
      neg5_r[h] <= neg4_r[h];
      x5_r[h]   <= x4_r[h];
      u5_r[h]   <= u_nxt[h];
      lane_r[h] <= lane_nxt[h];
    end
  end

  // A7: sum of active harmonics
  logic        sneg_r;
  logic [16:0] smag_r;
  logic [1:0]  cnt_r;
  logic signed [17:0] sum;

  always_comb begin
    sum = 18'(lane_r[0]);
    if (add2) sum = sum + 18'(lane_r[1]);
    if (add3) sum = sum + 18'(lane_r[2]);
  end

  always_ff @(posedge clk) begin
    sneg_r <= sum[17];
    smag_r <= sum[17] ? 17'(-sum) : sum[16:0];
    cnt_r  <= 2'd1 + {1'b0, add2} + {1'b0, add3};
  end

  // A8: divide by harmonic count, toward zero
  logic [14:0] nmag_r;
  logic        nneg_r;
  logic [32:0] by3;
  logic [14:0] nmag_nxt;

  always_comb begin
    by3 = smag_r * 16'd43691;           // x/3 exact below 2^17
    case (cnt_r)
      2'd1:    nmag_nxt = smag_r[14:0];
      2'd2:    nmag_nxt = smag_r[15:1];
      default: nmag_nxt = by3[31:17];
    endcase
  end

  always_ff @(posedge clk) begin
    nmag_r <= nmag_nxt;
    nneg_r <= sneg_r;
  end

  assign mix = '{neg: nneg_r, mag: nmag_r};

endmodule
`default_nettype wire

// ===== rtl/adsr_harmonic_voice_sample_unit.sv =====
// ADSR voice sample unit: one note item in, one 16-bit sample out, fully
// pipelined. A new item is taken every cycle (busy stays low); each result
// leaves on out_strobe after segment decode, numerator setup, the 17-stage
// envelope divider, the envelope finish stage and two output scaling stages.
// The receiver cannot stall. The user must write the registers over APB only
// while no item is in flight; the block itself does not enforce it. Depends on
// adsrv_pkg, adsrv_env, adsrv_osc and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module adsr_harmonic_voice_sample_unit #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire adsrv_pkg::in_item_t  in_item,
  output logic                      out_strobe,
  output adsrv_pkg::out_item_t      out_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import adsrv_pkg::*;

  localparam int DLY = ENV_LAT - OSC_LAT;

  // configuration registers
  logic [23:0] attack_r, decay_r, release_r;
  logic [15:0] vel_r;
  logic        harm2_r, harm3_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= 24'd6554;
      decay_r   <= 24'd6554;
      release_r <= 24'd6554;
      vel_r     <= 16'd32768;
      harm2_r   <= 1'b0;
      harm3_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_r  <= pwdata[23:0];
        REG_DECAY:   decay_r   <= pwdata[23:0];
        REG_RELEASE: release_r <= pwdata[23:0];
        REG_VEL:     vel_r     <= pwdata[15:0];
        REG_HARM2:   harm2_r   <= pwdata[0];
        REG_HARM3:   harm3_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = {8'd0, attack_r};
      REG_DECAY:   prdata = {8'd0, decay_r};
      REG_RELEASE: prdata = {8'd0, release_r};
      REG_VEL:     prdata = {16'd0, vel_r};
      REG_HARM2:   prdata = {31'd0, harm2_r};
      REG_HARM3:   prdata = {31'd0, harm3_r};
      default:     prdata = 32'd0;
    endcase
  end

  env_res_t env_res;
  mix_t     mix;

  adsrv_env u_env (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start && !busy),
    .t            (in_item.time_since_on),
    .held         (in_item.held_length),
    .attack_time  (attack_r),
    .decay_time   (decay_r),
    .release_time (release_r),
    .env_res      (env_res)
  );

  adsrv_osc #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_osc (
    .clk  (clk),
    .note (in_item.note_number),
    .t    (in_item.time_since_on),
    .add2 (harm2_r),
    .add3 (harm3_r),
    .mix  (mix)
  );

  // align the oscillator with the envelope result
  mix_t mix_dly_r [DLY];

  always_ff @(posedge clk) begin
    mix_dly_r[0] <= mix;
    for (int i = 1; i < DLY; i++) mix_dly_r[i] <= mix_dly_r[i - 1];
  end

  // M1: magnitude times envelope
  logic        m1_v_r;
  logic [2:0]  m1_seg_r;
  logic        m1_neg_r;
  logic [31:0] m1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= env_res.valid;
    end
    m1_seg_r <= env_res.seg;
    m1_neg_r <= mix_dly_r[DLY - 1].neg;
    m1_p_r   <= mix_dly_r[DLY - 1].mag * env_res.env;
  end

  // M2: velocity gain, rounding and saturation
  logic [47:0] p2;
  logic [16:0] mag;
  logic signed [15:0] smp_nxt;
  logic        out_v_r;
  out_item_t   out_r;

  always_comb begin
    p2  = (m1_p_r * vel_r) + 48'h0000_4000_0000;
    mag = p2[47:31];
    if (mag > 17'd32768) mag = 17'd32768;
    if (m1_seg_r == SEG_SILENT) begin
      smp_nxt = 16'sd0;
    end else if (m1_neg_r) begin
      smp_nxt = $signed(16'(17'd0 - mag));
    end else if (mag > 17'd32767) begin
      smp_nxt = 16'sd32767;
    end else begin
      smp_nxt = $signed(mag[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= m1_v_r;
    end
    out_r.voice_sample <= smp_nxt;
    out_r.segment      <= m1_seg_r;
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  `ASSERT_CLK(a_latency, (start && !busy) |-> ##22 out_strobe, "result missing after transaction")
  `ASSERT_CLK(a_silent_zero, (out_strobe && out_item.segment == SEG_SILENT) |-> (out_item.voice_sample == 16'sd0), "silent segment with nonzero sample")
  `ASSERT_NEXT(a_env_valid, env_res.valid, m1_v_r, "envelope slot lost in scaling")

endmodule
`default_nettype wire

// ===== tb/sv/tb_adsr_harmonic_voice_sample_unit.sv =====
// Self-checking testbench for adsr_harmonic_voice_sample_unit.
// Drives note items and APB register writes, predicts every sample in a local
// fixed-point voice model. Depends on adsrv_pkg and the unit's RTL.
`default_nettype none
module tb_adsr_harmonic_voice_sample_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import adsrv_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  // indexes past the last register, writes there are dropped
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adsr_harmonic_voice_sample_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow register file
  logic [23:0] attack_r, decay_r, release_r;
  logic [15:0] vel_r;
  logic        harm2_r, harm3_r;

  out_item_t   sample_q[$];
  int          mismatches;
  int          quiet_cycles;
  bit          gaps_on;

  const logic [31:0] semitone_hz[12] = '{
    32'd17146184, 32'd18165268, 32'd19245302, 32'd20390216, 32'd21602632, 32'd22913352,
    32'd24247927, 32'd25690112, 32'd27217428, 32'd28835840, 32'd30550524, 32'd32366920
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] osc_phase(logic [6:0] note, logic [31:0] t, int h);
    int oct;
    longint unsigned prod;
    oct = int'(note) / 12 - 5;
    prod = longint'(semitone_hz[note % 12]) * longint'(t) * longint'(h);
    if (oct >= 0) prod = prod << oct;
    else prod = prod >> (-oct);
    return prod[31:0];
  endfunction

  function automatic int quant_sine(logic [31:0] phase);
    logic [31:0] p;
    logic [1:0] quad;
    longint unsigned x, x2, tt, u, s;
    p = {phase[31:22], 22'd0};
    quad = p[31:30];
    x = p[29:14];
    if (quad[0]) x = 64'd65536 - x;
    x2 = (x * x) >> 16;
    tt = 64'd42048 - ((64'd4640 * x2) >> 16);
    u = 64'd102944 - ((x2 * tt) >> 16);
    s = (x * u) >> 16;
    s = (s + 1) >> 1;
    if (s > 32767) s = 32767;
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  function automatic out_item_t voice_sample_of(in_item_t it);
    out_item_t r;
    longint unsigned t, t1, t2, t4, env, mag;
    longint val;
    int sum, cnt, n;
    t = it.time_since_on;
    t1 = attack_r;
    t2 = t1 + decay_r;
    t4 = longint'(it.held_length) + release_r;
    if (t >= t4) begin
      r.voice_sample = '0;
      r.segment = SEG_SILENT;
      return r;
    end
    if (t <= t1) begin
      r.segment = SEG_ATTACK;
      env = (t1 == 0) ? 64'd65536 : (t * 64'd65536) / t1;
    end else if (t <= t2) begin
      r.segment = SEG_DECAY;
      env = 64'd65536 - (64'd13107 * (t - t1)) / decay_r;
    end else if (t <= it.held_length) begin
      r.segment = SEG_SUSTAIN;
      env = 64'd52429;
    end else begin
      r.segment = SEG_RELEASE;
      env = 64'd52429 - (64'd52429 * (t - it.held_length)) / release_r;
    end
    sum = quant_sine(osc_phase(it.note_number, it.time_since_on, 1));
    cnt = 1;
    if (harm2_r) begin
      sum += quant_sine(osc_phase(it.note_number, it.time_since_on, 2));
      cnt++;
    end
    if (harm3_r) begin
      sum += quant_sine(osc_phase(it.note_number, it.time_since_on, 3));
      cnt++;
    end
    n = sum / cnt;
    mag = longint'(n < 0 ? -n : n) * env * longint'(vel_r);
    mag = (mag + (64'd1 << 30)) >> 31;
    if (mag > 32768) mag = 32768;
    val = (n < 0) ? -longint'(mag) : longint'(mag);
    if (val > 32767) val = 32767;
    r.voice_sample = val[15:0];
    return r;
  endfunction

  // prediction at acceptance, checking at each strobe
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sample_q.insert(sample_q.size(), voice_sample_of(in_item));
      if (out_strobe) begin
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d seg %0d",
                                         out_item.voice_sample, out_item.segment);
        end else begin
          out_item_t want;
          want = sample_q.pop_front();
          if (out_item.voice_sample !== want.voice_sample || out_item.segment !== want.segment) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample exp %0d got %0d, segment exp %0d got %0d",
                       want.voice_sample, out_item.voice_sample, want.segment, out_item.segment);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_ATTACK:  attack_r = value[23:0];
      REG_DECAY:   decay_r = value[23:0];
      REG_RELEASE: release_r = value[23:0];
      REG_VEL:     vel_r = value[15:0];
      REG_HARM2:   harm2_r = value[0];
      REG_HARM3:   harm3_r = value[0];
      default: ;
    endcase
  endtask

  task automatic set_voice(logic [23:0] a, logic [23:0] d, logic [23:0] r,
                           logic [15:0] v, bit h2, bit h3);
    // upper bits of most writes carry junk to show the registers ignore them
    reg_write(REG_ATTACK, {8'($urandom_range(0, 255)), a});
    reg_write(REG_DECAY, {8'hA5, d});
    reg_write(REG_RELEASE, {8'($urandom_range(0, 255)), r});
    reg_write(REG_VEL, {16'h5A5A, v});
    reg_write(REG_HARM2, {31'h2, h2});
    reg_write(REG_HARM3, {31'h0, h3});
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_note(logic [6:0] note, logic [31:0] t, logic [31:0] held);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_item.note_number = note;
    in_item.time_since_on = t;
    in_item.held_length = held;
    do @(posedge clk); while (busy);
  endtask

  task automatic end_burst();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_random_note();
    logic [31:0] held, t, t2, t4;
    int mode;
    mode = $urandom_range(0, 9);
    t2 = attack_r + decay_r;
    held = (mode == 9) ? $urandom : $urandom_range(0, 2 * t2 + 4000);
    t4 = held + release_r;
    case ($urandom_range(0, 9))
      0: t = attack_r;
      1: t = t2;
      2: t = held;
      3: t = t4 - 1;
      4: t = t4;
      5: t = $urandom;
      default: t = $urandom_range(0, t4 + 100);
    endcase
    send_note(7'($urandom_range(0, 127)), t, held);
  endtask

  task automatic test_reset_defaults();
    send_note(7'd60, 32'd0, 32'd100000);
    send_note(7'd69, 32'd3277, 32'd100000);
    send_note(7'd71, 32'd6554, 32'd100000);
    send_note(7'd64, 32'd9000, 32'd100000);
    send_note(7'd65, 32'd50000, 32'd20000);
    send_note(7'd0, 32'd26553, 32'd20000);
    send_note(7'd127, 32'd26554, 32'd20000);
    send_note(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end_burst();
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    // instant rise with every harmonic and gain above unity
    set_voice(24'd0, 24'd1, 24'd1, 16'hFFFF, 1'b1, 1'b1);
    reg_write(REG_SPARE0, 32'hFFFF_FFFF);
    reg_write(REG_SPARE1, 32'h0000_0000);
    send_note(7'd60, 32'd0, 32'd10);
    send_note(7'd0, 32'd1, 32'd10);
    send_note(7'd127, 32'd5, 32'd10);
    send_note(7'd100, 32'd10, 32'd10);
    send_note(7'd33, 32'd11, 32'd10);
    send_note(7'd33, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    end_burst();
    wait_idle();
    set_voice(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 1'b0, 1'b1);
    send_note(7'd72, 32'hFF_FFFF, 32'hFFFF_FFFF);
    send_note(7'd59, 32'h1FF_FFFE, 32'hFFFF_FFFF);
    send_note(7'd59, 32'hFFFF_FFFF, 32'h0);
    end_burst();
    wait_idle();
    set_voice(24'd1000, 24'd0, 24'd500, 16'd32768, 1'b1, 1'b0);
    send_note(7'd48, 32'd1000, 32'd900);
    send_note(7'd48, 32'd1001, 32'd900);
    send_note(7'd84, 32'd1200, 32'd1100);
    send_note(7'd84, 32'd1599, 32'd1100);
    end_burst();
    wait_idle();
  endtask

  task automatic test_random_voices(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 4))
        0: set_voice(24'($urandom_range(0, 3)), 24'($urandom_range(0, 3)),
                     24'($urandom_range(1, 3)), 16'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: set_voice(24'($urandom), 24'($urandom), 24'($urandom),
                     16'($urandom_range(0, 32768)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: set_voice(24'($urandom_range(0, 20000)), 24'($urandom_range(0, 20000)),
                           24'($urandom_range(0, 20000)), 16'($urandom_range(16384, 40000)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      for (int i = 0; i < per_phase; i++) send_random_note();
      end_burst();
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    attack_r = 24'd6554; decay_r = 24'd6554; release_r = 24'd6554;
    vel_r = 16'd32768; harm2_r = 1'b0; harm3_r = 1'b0;
    mismatches = 0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_directed_extremes();
    test_random_voices(12, 125);
    gaps_on = 1'b0;
    test_random_voices(3, 100);

    wait_idle();
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
